/* rtl/core/cckb_pkg.sv */
// ----------------------------------------------------------------------------
// Clipped color key blit package
// Shared widths, payload types, register indexes and a helper function.
// ----------------------------------------------------------------------------
package cckb_pkg;

    // Defaults for the top level parameters.
    localparam int PIXEL_BYTES_DEF = 4;
    localparam int MAX_DIM_DEF     = 4096;

    // Fixed field widths.
    localparam int POS_W   = 14;
    localparam int DIM_W   = 13;
    localparam int EDIM_W  = DIM_W + 1;
    localparam int CNT_W   = 13;
    localparam int IDX_W   = 24;
    localparam int PIX_W   = 32;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration register indexes.
    typedef enum logic [CFG_A_W-1:0] {
        REG_PLACE_X       = 3'd0,
        REG_PLACE_Y       = 3'd1,
        REG_SOURCE_WIDTH  = 3'd2,
        REG_SOURCE_HEIGHT = 3'd3,
        REG_TARGET_WIDTH  = 3'd4,
        REG_TARGET_HEIGHT = 3'd5,
        REG_KEY_COLOR     = 3'd6,
        REG_KEY_ENABLE    = 3'd7
    } t_cfg_index;

    // Input item.
    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             first_pixel;
    } t_pixel_in;

    // Result item.
    typedef struct packed {
        logic [IDX_W-1:0] target_index;
        logic [PIX_W-1:0] write_value;
    } t_pixel_out;

    // Register file contents as seen by the datapath.
    typedef struct packed {
        logic [POS_W-1:0] place_x;
        logic [POS_W-1:0] place_y;
        logic [DIM_W-1:0] source_width;
        logic [DIM_W-1:0] source_height;
        logic [DIM_W-1:0] target_width;
        logic [DIM_W-1:0] target_height;
        logic [PIX_W-1:0] key_color;
        logic             key_enable;
    } t_cfg;

    // Limit a dimension register to the largest supported dimension.
    function automatic logic [EDIM_W-1:0] f_dim(input logic [DIM_W-1:0] v,
                                                input logic [EDIM_W-1:0] max_dim);
        logic [EDIM_W-1:0] ext;
        ext = {1'b0, v};
        return (ext > max_dim) ? max_dim : ext;
    endfunction

endpackage

/* rtl/core/cckb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Clipped color key blit configuration registers
// Holds the placement, image sizes and key settings written over the
// configuration channel.
// ----------------------------------------------------------------------------
module cckb_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cckb_pkg::CFG_A_W-1:0]     i_cfg_index,
    input  logic [cckb_pkg::CFG_D_W-1:0]     i_cfg_data,
    output cckb_pkg::t_cfg                   o_cfg
);

    cckb_pkg::t_cfg r_cfg;
    cckb_pkg::t_cfg n_cfg;

    // Writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Decode the register index.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (cckb_pkg::t_cfg_index'(i_cfg_index))
                cckb_pkg::REG_PLACE_X:
                    n_cfg.place_x = i_cfg_data[cckb_pkg::POS_W-1:0];
                cckb_pkg::REG_PLACE_Y:
                    n_cfg.place_y = i_cfg_data[cckb_pkg::POS_W-1:0];
                cckb_pkg::REG_SOURCE_WIDTH:
                    n_cfg.source_width = i_cfg_data[cckb_pkg::DIM_W-1:0];
                cckb_pkg::REG_SOURCE_HEIGHT:
                    n_cfg.source_height = i_cfg_data[cckb_pkg::DIM_W-1:0];
                cckb_pkg::REG_TARGET_WIDTH:
                    n_cfg.target_width = i_cfg_data[cckb_pkg::DIM_W-1:0];
                cckb_pkg::REG_TARGET_HEIGHT:
                    n_cfg.target_height = i_cfg_data[cckb_pkg::DIM_W-1:0];
                cckb_pkg::REG_KEY_COLOR:
                    n_cfg.key_color = i_cfg_data[cckb_pkg::PIX_W-1:0];
                cckb_pkg::REG_KEY_ENABLE:
                    n_cfg.key_enable = i_cfg_data[0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    // All registers clear at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/cckb_step.sv */
// ----------------------------------------------------------------------------
// Clipped color key blit pixel step
// Raster counters, clip tests, key compare and destination index for one
// source pixel.
// ----------------------------------------------------------------------------
module cckb_step #(
    parameter int PIXEL_BYTES = cckb_pkg::PIXEL_BYTES_DEF,
    parameter int MAX_DIM     = cckb_pkg::MAX_DIM_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cckb_pkg::t_cfg         i_cfg,
    input  logic                   i_accept,
    input  cckb_pkg::t_pixel_in    i_item,
    output logic                   o_res_valid,
    output cckb_pkg::t_pixel_out   o_res
);

    localparam int EW = cckb_pkg::EDIM_W;
    localparam int PW = cckb_pkg::POS_W;
    localparam int CW = cckb_pkg::CNT_W;
    localparam int XW = cckb_pkg::IDX_W;

    localparam logic [EW-1:0] MAX_D = EW'(MAX_DIM);
    localparam logic [cckb_pkg::PIX_W-1:0] PIX_MASK =
        (PIXEL_BYTES >= 4) ? {cckb_pkg::PIX_W{1'b1}}
                           : cckb_pkg::PIX_W'((64'd1 << (8 * PIXEL_BYTES)) - 64'd1);

    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [XW-1:0] r_base;
    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;
    logic [XW-1:0] n_base;

    logic [EW-1:0]   sw_eff;
    logic [EW-1:0]   sh_eff;
    logic [EW-1:0]   tw_eff;
    logic [EW-1:0]   th_eff;
    logic signed [PW+EW:0] origin_prod;
    logic signed [PW+EW:0] origin_sum;
    logic [CW-1:0]   col_cur;
    logic [CW-1:0]   row_cur;
    logic [XW-1:0]   base_cur;
    logic [PW:0]     dx;
    logic [PW:0]     dy;
    logic            in_overlap;
    logic            keyed;
    logic [cckb_pkg::PIX_W-1:0] pix;
    logic [CW:0]     col_inc;
    logic            wrap;

    // Effective dimensions after limiting to the supported maximum.
    assign sw_eff = cckb_pkg::f_dim(i_cfg.source_width, MAX_D);
    assign sh_eff = cckb_pkg::f_dim(i_cfg.source_height, MAX_D);
    assign tw_eff = cckb_pkg::f_dim(i_cfg.target_width, MAX_D);
    assign th_eff = cckb_pkg::f_dim(i_cfg.target_height, MAX_D);

    // Destination index of the source origin, used to restart the row base.
    assign origin_prod = $signed(i_cfg.place_y) * $signed({1'b0, tw_eff});
    assign origin_sum  = origin_prod + (PW+EW+1)'($signed(i_cfg.place_x));

    // Counters as seen by the current item; the first pixel restarts them.
    assign col_cur  = i_item.first_pixel ? '0 : r_col;
    assign row_cur  = i_item.first_pixel ? '0 : r_row;
    assign base_cur = i_item.first_pixel ? origin_sum[XW-1:0] : r_base;

    // Position in the destination, one bit wider than the placement.
    assign dx = {i_cfg.place_x[PW-1], i_cfg.place_x} + (PW+1)'(col_cur);
    assign dy = {i_cfg.place_y[PW-1], i_cfg.place_y} + (PW+1)'(row_cur);

    // Clip on both images and both axes.
    assign in_overlap = ({1'b0, col_cur} < sw_eff) && ({1'b0, row_cur} < sh_eff) &&
                        !dx[PW] && (dx[PW-1:0] < tw_eff) &&
                        !dy[PW] && (dy[PW-1:0] < th_eff);

    // Color key compare on the pixel bits only.
    assign pix   = i_item.pixel_value & PIX_MASK;
    assign keyed = i_cfg.key_enable && (pix == (i_cfg.key_color & PIX_MASK));

    assign o_res_valid         = in_overlap && !keyed;
    assign o_res.target_index  = base_cur + XW'(col_cur);
    assign o_res.write_value   = pix;

    // Raster advance: wrap the column at the source width, saturate the row.
    always_comb begin
        col_inc = {1'b0, col_cur} + (CW+1)'(1);
        wrap    = col_inc >= (CW+1)'(sw_eff);
        n_col   = col_inc[CW-1:0];
        n_row   = row_cur;
        n_base  = base_cur;
        if (wrap) begin
            n_col  = '0;
            n_base = base_cur + XW'(tw_eff);
            if (row_cur != cckb_pkg::CNT_MAX) begin
                n_row = row_cur + CW'(1);
            end
        end
    end

    // Counter registers update once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_base <= '0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_base <= n_base;
        end
    end

    // The column counter never reaches the largest supported width.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW+1)'(r_col) < (CW+1)'(MAX_D))
        else $error("column counter out of range");

    // A first pixel leaves the row counter at zero or one.
    a_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.first_pixel |=> r_row <= CW'(1))
        else $error("row counter not restarted");

    // Without a first pixel the row counter never moves back.
    a_row_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_item.first_pixel |=> r_row >= $past(r_row))
        else $error("row counter moved back");

endmodule

/* rtl/core/clipped_color_key_blit_core.sv */
// ----------------------------------------------------------------------------
// Clipped color key blit core
// Places a source image in a destination image, clips to the overlap and
// drops color-keyed pixels, emitting destination index and value.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration is written over the cfg channel (index, data) while the
//   block is idle; writes are always accepted and take effect on the next
//   item. Source pixels enter in raster order on the input channel, with
//   first_pixel set on row 0, column 0 to restart the raster counters.
//   Each pixel inside the overlap and not matching an enabled key produces one
//   item on the output channel; other pixels produce nothing.
//   A result sits in the output register in the cycle after its pixel is
//   accepted. Throughput is one pixel per cycle while the receiver does not
//   stall, set by the combinational clip, key and index logic between the
//   input handshake and the output register. When the receiver stalls, the
//   output register holds its item and input ready drops until that item is
//   taken; an item is taken in the same cycle as the held one leaves.
//   Reset clears the configuration registers, the raster counters and the output valid.
// ----------------------------------------------------------------------------
module clipped_color_key_blit_core #(
    parameter int PIXEL_BYTES = cckb_pkg::PIXEL_BYTES_DEF,
    parameter int MAX_DIM     = cckb_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cckb_pkg::CFG_A_W-1:0]  i_cfg_index,
    input  logic [cckb_pkg::CFG_D_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cckb_pkg::t_pixel_in           i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cckb_pkg::t_pixel_out          o_out_item
);

    cckb_pkg::t_cfg       cfg;
    cckb_pkg::t_pixel_out res;
    logic                 res_valid;
    logic                 in_accept;

    logic                 r_out_valid;
    cckb_pkg::t_pixel_out r_out_item;

    // Configuration registers.
    cckb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input is taken whenever the output register is free or draining.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // Per-pixel datapath and raster counters.
    cckb_step #(
        .PIXEL_BYTES (PIXEL_BYTES),
        .MAX_DIM     (MAX_DIM)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (in_accept),
        .i_item      (i_in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A held result blocks the input until the receiver takes it.
    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken over a held result");

    // A result appears only after an accepted item.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_accept))
        else $error("result without an accepted item");

    // A delivered result with no new item leaves the output empty.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_ready && !in_accept |=> !r_out_valid)
        else $error("result delivered twice");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clipped color key blit testbench
// Configures placement, image sizes and color key between frames, streams
// source pixels in raster order and checks every destination write against
// a cycle-free model of the clip, key and index logic or the directed table.
// ----------------------------------------------------------------------------
module tb_top;
    import cckb_pkg::*;

    localparam int PIXEL_BYTES    = PIXEL_BYTES_DEF;
    localparam int MAX_DIM        = MAX_DIM_DEF;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 29;
    localparam int CALM_FROM      = 250;
    localparam int CALM_TO        = 330;
    localparam int HOLD_AT        = 80;
    localparam int HOLD_CYCLES    = 64;
    localparam int RANDOM_ITEMS   = 425;
    localparam int FRAME_CAP      = 40;
    localparam bit KNOWN          = 1'b1;
    localparam bit PREDICT        = 1'b0;

    localparam logic [PIX_W-1:0] PIX_MASK = (PIXEL_BYTES >= 4) ? {PIX_W{1'b1}} :
        PIX_W'((64'd1 << (8 * PIXEL_BYTES)) - 64'd1);

    typedef enum logic {
        ROW_CFG,
        ROW_PIX
    } t_row_kind;

    // One line of the directed stimulus table.
    typedef struct {
        t_row_kind        kind;
        t_cfg_index       index;
        logic [CFG_D_W-1:0] data;
        t_pixel_in        pixel;
        bit               known;
        bit               known_hit;
        logic [IDX_W-1:0] known_index;
    } t_row;

    // Block ports.
    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_A_W-1:0]   cfg_index = '0;
    logic [CFG_D_W-1:0]   cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_pixel_in            in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_pixel_out           out_item;

    // Register mirror and raster state of the model.
    logic signed [POS_W-1:0] cfg_place_x = '0;
    logic signed [POS_W-1:0] cfg_place_y = '0;
    logic [DIM_W-1:0]        cfg_src_w   = '0;
    logic [DIM_W-1:0]        cfg_src_h   = '0;
    logic [DIM_W-1:0]        cfg_dst_w   = '0;
    logic [DIM_W-1:0]        cfg_dst_h   = '0;
    logic [PIX_W-1:0]        cfg_key     = '0;
    logic                    cfg_key_en  = 1'b0;
    logic [CNT_W-1:0]        blit_col      = '0;
    logic [CNT_W-1:0]        blit_row      = '0;
    logic [IDX_W-1:0]        blit_row_base = '0;

    t_pixel_out pending_writes[$];
    t_row       directed_rows[$];

    int n_sent       = 0;
    int n_accepted   = 0;
    int n_checked    = 0;
    int n_errors     = 0;
    int n_phases     = 0;
    int stall_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    clipped_color_key_blit_core #(
        .PIXEL_BYTES (PIXEL_BYTES),
        .MAX_DIM     (MAX_DIM)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // Free-running clock.
    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Dimension registers above the supported maximum act as the maximum.
    function automatic int dim_limit(input logic [DIM_W-1:0] v);
        return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic bit calm_window();
        return n_accepted >= CALM_FROM && n_accepted < CALM_TO;
    endfunction

    function automatic void mirror_reg_write(input t_cfg_index index,
                                             input logic [CFG_D_W-1:0] data);
        case (index)
            REG_PLACE_X:       cfg_place_x = data[POS_W-1:0];
            REG_PLACE_Y:       cfg_place_y = data[POS_W-1:0];
            REG_SOURCE_WIDTH:  cfg_src_w   = data[DIM_W-1:0];
            REG_SOURCE_HEIGHT: cfg_src_h   = data[DIM_W-1:0];
            REG_TARGET_WIDTH:  cfg_dst_w   = data[DIM_W-1:0];
            REG_TARGET_HEIGHT: cfg_dst_h   = data[DIM_W-1:0];
            REG_KEY_COLOR:     cfg_key     = data[PIX_W-1:0];
            REG_KEY_ENABLE:    cfg_key_en  = data[0];
            default:           cfg_key_en  = cfg_key_en;
        endcase
    endfunction

    // Works out the destination write for one source pixel and advances the
    // raster counters. Returns 1 when the pixel lands inside the overlap and
    // is not the key color.
    function automatic bit predict_blit_write(input t_pixel_in item,
                                              output t_pixel_out res);
        logic [PIX_W-1:0] pix;
        int src_w, src_h, dst_w, dst_h, dx, dy, next_col;
        bit hit;
        pix   = item.pixel_value & PIX_MASK;
        src_w = dim_limit(cfg_src_w);
        src_h = dim_limit(cfg_src_h);
        dst_w = dim_limit(cfg_dst_w);
        dst_h = dim_limit(cfg_dst_h);
        if (item.first_pixel) begin
            blit_col      = '0;
            blit_row      = '0;
            blit_row_base = IDX_W'(int'(cfg_place_y) * dst_w + int'(cfg_place_x));
        end
        dx  = int'(cfg_place_x) + int'(blit_col);
        dy  = int'(cfg_place_y) + int'(blit_row);
        hit = int'(blit_col) < src_w && int'(blit_row) < src_h &&
              dx >= 0 && dx < dst_w && dy >= 0 && dy < dst_h &&
              !(cfg_key_en && pix == (cfg_key & PIX_MASK));
        res.target_index = blit_row_base + IDX_W'(blit_col);
        res.write_value  = pix;
        // Row advance; the row counter saturates past the last row.
        next_col = int'(blit_col) + 1;
        if (next_col >= src_w) begin
            blit_col = '0;
            if (blit_row != CNT_MAX) begin
                blit_row = blit_row + CNT_W'(1);
            end
            blit_row_base = blit_row_base + IDX_W'(dst_w);
        end else begin
            blit_col = CNT_W'(next_col);
        end
        return hit;
    endfunction

    // Random upper bits above the field the register keeps.
    function automatic logic [CFG_D_W-1:0] with_noise(input int value, input int width);
        logic [CFG_D_W-1:0] mask;
        mask = (width >= CFG_D_W) ? '1 : ((32'd1 << width) - 32'd1);
        return ($urandom & ~mask) | (CFG_D_W'(value) & mask);
    endfunction

    // Mostly small images, now and then empty, large or oversize.
    function automatic int pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 75) return $urandom_range(16, 1);
        if (r < 90) return $urandom_range(MAX_DIM, 17);
        return $urandom_range(8191, MAX_DIM + 1);
    endfunction

    // Placement near the destination so that clipping hits every edge.
    function automatic int pick_place(input int src, input int dst);
        int r, lo, hi;
        r  = $urandom_range(99);
        lo = (src > 20) ? 20 : src;
        hi = (dst > 20) ? 20 : dst;
        if (r < 10) return ($urandom_range(1) == 0) ? -8192 : 8191;
        if (r < 25) return int'($urandom_range(16383)) - 8192;
        return int'($urandom_range(lo + hi)) - lo;
    endfunction

    function automatic void add_cfg_row(input t_cfg_index index,
                                        input logic [CFG_D_W-1:0] data);
        t_row row;
        row.kind        = ROW_CFG;
        row.index       = index;
        row.data        = data;
        row.pixel       = '0;
        row.known       = 1'b0;
        row.known_hit   = 1'b0;
        row.known_index = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pixel_row(input logic [PIX_W-1:0] pix, input bit first,
                                          input bit known, input bit known_hit,
                                          input logic [IDX_W-1:0] known_index);
        t_row row;
        row.kind              = ROW_PIX;
        row.index             = REG_PLACE_X;
        row.data              = '0;
        row.pixel.pixel_value = pix;
        row.pixel.first_pixel = first;
        row.known             = known;
        row.known_hit         = known_hit;
        row.known_index       = known_index;
        directed_rows.push_back(row);
    endfunction

    // Drops both valids and lets the block drain before a register write.
    task automatic wait_idle();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index index, input logic [CFG_D_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        mirror_reg_write(index, data);
    endtask

    // Offers one pixel item, with random gaps, and records its expected write.
    task automatic send_pixel(input t_pixel_in item, input bit known, input bit known_hit,
                              input logic [IDX_W-1:0] known_index);
        t_pixel_out predicted;
        bit hit;
        cfg_valid <= 1'b0;
        while (!calm_window() && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        hit = predict_blit_write(item, predicted);
        if (known) begin
            hit                    = known_hit;
            predicted.target_index = known_index;
            predicted.write_value  = item.pixel_value & PIX_MASK;
        end
        if (hit) begin
            pending_writes.push_back(predicted);
        end
        n_sent++;
    endtask

    // New random setting of every register.
    task automatic random_config();
        int src_w, src_h, dst_w, dst_h;
        src_w = pick_dim();
        src_h = pick_dim();
        dst_w = pick_dim();
        dst_h = pick_dim();
        wait_idle();
        write_reg(REG_PLACE_X, with_noise(pick_place(dim_limit(DIM_W'(src_w)),
                                                     dim_limit(DIM_W'(dst_w))), POS_W));
        write_reg(REG_PLACE_Y, with_noise(pick_place(dim_limit(DIM_W'(src_h)),
                                                     dim_limit(DIM_W'(dst_h))), POS_W));
        write_reg(REG_SOURCE_WIDTH, with_noise(src_w, DIM_W));
        write_reg(REG_SOURCE_HEIGHT, with_noise(src_h, DIM_W));
        write_reg(REG_TARGET_WIDTH, with_noise(dst_w, DIM_W));
        write_reg(REG_TARGET_HEIGHT, with_noise(dst_h, DIM_W));
        write_reg(REG_KEY_COLOR, $urandom);
        write_reg(REG_KEY_ENABLE, with_noise($urandom_range(1), 1));
        n_phases++;
    endtask

    // One raster frame, usually whole and well formed; some are cut short,
    // run past the end, lack the first-pixel flag or restart mid frame.
    task automatic random_frame();
        int span, len, r;
        t_pixel_in item;
        span = dim_limit(cfg_src_w) * dim_limit(cfg_src_h);
        if (span > FRAME_CAP) span = FRAME_CAP;
        len = span + $urandom_range(3);
        if ($urandom_range(99) < 15) len = $urandom_range(len);
        for (int i = 0; i < len; i++) begin
            item.first_pixel = (i == 0) ? ($urandom_range(99) < 90) : ($urandom_range(99) < 3);
            r = $urandom_range(99);
            if (r < 20) begin
                item.pixel_value = cfg_key;
            end else if (r < 25) begin
                item.pixel_value = '0;
            end else if (r < 30) begin
                item.pixel_value = '1;
            end else begin
                item.pixel_value = $urandom;
            end
            send_pixel(item, PREDICT, 1'b0, '0);
        end
    endtask

    // Output ready: random stalls, one long hold-off and a calm stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!hold_done && in_valid && n_accepted >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm_window() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result checker and handshake activity counter.
    always @(posedge i_clk) begin : check_writes
        t_pixel_out want;
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (in_valid && in_ready) begin
                n_accepted <= n_accepted + 1;
            end
            if (out_valid && out_ready) begin
                n_checked <= n_checked + 1;
                if (pending_writes.size() == 0) begin
                    $display("%0t: unexpected write, index %h value %h",
                             $time, out_item.target_index, out_item.write_value);
                    n_errors++;
                end else begin
                    want = pending_writes.pop_front();
                    if (out_item.target_index !== want.target_index) begin
                        $display("%0t: target_index expected %h actual %h",
                                 $time, want.target_index, out_item.target_index);
                        n_errors++;
                    end
                    if (out_item.write_value !== want.write_value) begin
                        $display("%0t: write_value expected %h actual %h",
                                 $time, want.write_value, out_item.write_value);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog on handshake activity.
    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Main stimulus.
    initial begin
        t_row_kind prev_kind;
        int n_directed;

        // All registers at reset: empty images drop everything.
        add_pixel_row(32'hFFFF_FFFF, 1'b1, KNOWN, 1'b0, '0);
        add_pixel_row(32'h0000_0000, 1'b0, KNOWN, 1'b0, '0);

        // 4x2 source at (-2, -1) in a 5x4 destination, keyed.
        add_cfg_row(REG_PLACE_X,       32'hFFFF_FFFE);
        add_cfg_row(REG_PLACE_Y,       32'h0000_3FFF);
        add_cfg_row(REG_SOURCE_WIDTH,  32'd4);
        add_cfg_row(REG_SOURCE_HEIGHT, 32'd2);
        add_cfg_row(REG_TARGET_WIDTH,  32'd5);
        add_cfg_row(REG_TARGET_HEIGHT, 32'd4);
        add_cfg_row(REG_KEY_COLOR,     32'h1234_5678);
        add_cfg_row(REG_KEY_ENABLE,    32'd1);
        add_pixel_row(32'hA5A5_0001, 1'b1, KNOWN, 1'b0, '0);
        add_pixel_row(32'hA5A5_0002, 1'b0, KNOWN, 1'b0, '0);
        add_pixel_row(32'hA5A5_0003, 1'b0, KNOWN, 1'b0, '0);
        add_pixel_row(32'hA5A5_0004, 1'b0, KNOWN, 1'b0, '0);
        add_pixel_row(32'hA5A5_0005, 1'b0, KNOWN, 1'b0, '0);
        add_pixel_row(32'hA5A5_0006, 1'b0, KNOWN, 1'b0, '0);
        // Columns 2 and 3 of row 1 land inside; column 2 goes to index zero and column 3 is keyed.
        add_pixel_row(32'hFFFF_FFFF, 1'b0, KNOWN, 1'b1, 24'd0);
        add_pixel_row(32'h1234_5678, 1'b0, KNOWN, 1'b0, '0);
        // Past the last row, then a restart mid frame.
        add_pixel_row(32'h0BAD_0BAD, 1'b0, KNOWN, 1'b0, '0);
        add_pixel_row(32'h5555_AAAA, 1'b1, KNOWN, 1'b0, '0);

        // Oversize widths act as the maximum; right edge of the destination.
        add_cfg_row(REG_PLACE_X,       32'd4095);
        add_cfg_row(REG_PLACE_Y,       32'd0);
        add_cfg_row(REG_SOURCE_WIDTH,  32'd8191);
        add_cfg_row(REG_SOURCE_HEIGHT, 32'd1);
        add_cfg_row(REG_TARGET_WIDTH,  32'd8191);
        add_cfg_row(REG_TARGET_HEIGHT, 32'd4096);
        add_cfg_row(REG_KEY_ENABLE,    32'd0);
        add_pixel_row(32'h0000_0000, 1'b1, KNOWN, 1'b1, 24'd4095);
        add_pixel_row(32'hFFFF_FFFF, 1'b0, KNOWN, 1'b0, '0);

        // Placement extremes.
        add_cfg_row(REG_PLACE_X,       32'h0000_2000);
        add_cfg_row(REG_PLACE_Y,       32'h0000_1FFF);
        add_pixel_row(32'hFFFF_FFFF, 1'b1, KNOWN, 1'b0, '0);

        // Key of zero in a 2x2 copy at the origin of a 3x3 destination.
        add_cfg_row(REG_PLACE_X,       32'd0);
        add_cfg_row(REG_PLACE_Y,       32'd0);
        add_cfg_row(REG_SOURCE_WIDTH,  32'd2);
        add_cfg_row(REG_SOURCE_HEIGHT, 32'd2);
        add_cfg_row(REG_TARGET_WIDTH,  32'd3);
        add_cfg_row(REG_TARGET_HEIGHT, 32'd3);
        add_cfg_row(REG_KEY_COLOR,     32'd0);
        add_cfg_row(REG_KEY_ENABLE,    32'd1);
        add_pixel_row(32'h0000_0000, 1'b1, KNOWN, 1'b0, '0);
        add_pixel_row(32'hFFFF_FFFF, 1'b0, KNOWN, 1'b1, 24'd1);
        add_pixel_row(32'h8000_0001, 1'b0, KNOWN, 1'b1, 24'd3);
        add_pixel_row(32'h0000_0000, 1'b0, KNOWN, 1'b0, '0);

        // Empty destination.
        add_cfg_row(REG_TARGET_WIDTH,  32'd0);
        add_pixel_row(32'h0000_0007, 1'b1, KNOWN, 1'b0, '0);

        // Source hanging over the left edge, checked by the model.
        add_cfg_row(REG_PLACE_X,       32'h0000_3FFD);
        add_cfg_row(REG_PLACE_Y,       32'd2);
        add_cfg_row(REG_SOURCE_WIDTH,  32'd5);
        add_cfg_row(REG_SOURCE_HEIGHT, 32'd3);
        add_cfg_row(REG_TARGET_WIDTH,  32'd7);
        add_cfg_row(REG_TARGET_HEIGHT, 32'd4);
        add_cfg_row(REG_KEY_ENABLE,    32'd0);
        add_pixel_row(32'hC0DE_0001, 1'b1, PREDICT, 1'b0, '0);
        add_pixel_row(32'hC0DE_0002, 1'b0, PREDICT, 1'b0, '0);
        add_pixel_row(32'hC0DE_0003, 1'b0, PREDICT, 1'b0, '0);
        add_pixel_row(32'hC0DE_0004, 1'b0, PREDICT, 1'b0, '0);
        add_pixel_row(32'hC0DE_0005, 1'b0, PREDICT, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        prev_kind  = ROW_PIX;
        n_directed = 0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                if (prev_kind == ROW_PIX) begin
                    wait_idle();
                end
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end else begin
                send_pixel(directed_rows[i].pixel, directed_rows[i].known,
                           directed_rows[i].known_hit, directed_rows[i].known_index);
                n_directed++;
            end
            prev_kind = directed_rows[i].kind;
        end

        // Random settings, each followed by a few frames.
        while (n_sent < n_directed + RANDOM_ITEMS) begin
            random_config();
            repeat ($urandom_range(3, 1)) random_frame();
        end

        wait_idle();
        $display("Sent %0d pixels over %0d random settings after the directed frames;",
                 n_sent, n_phases);
        $display("%0d writes checked, covering clipping on all four edges, keying,",
                 n_checked);
        $display("empty and oversize images, restarts and a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/cckb_pkg.sv
rtl/core/cckb_cfg_regs.sv
rtl/core/cckb_step.sv
rtl/core/clipped_color_key_blit_core.sv
test/tb_top.sv
